// ===== sv/easter_holiday_date_assert.svh =====
// Assertion helpers for the checker in ehd_check.sv.
`ifndef EASTER_HOLIDAY_DATE_ASSERT_SVH
`define EASTER_HOLIDAY_DATE_ASSERT_SVH

// Checked on every edge outside of reset.
`define EHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define EHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ehd_pkg.sv =====
`default_nettype none

package ehd_pkg;

  // Field types
  typedef logic [13:0] year_t;
  typedef logic [2:0]  mode_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [8:0]  doy_t;

  // Pipeline depth, input register to output register
  localparam int NSTAGE = 8;

  // Holiday selector codes
  localparam mode_t MODE_EASTER      = 3'd0;
  localparam mode_t MODE_CARNIVAL    = 3'd1;
  localparam mode_t MODE_GOOD_FRIDAY = 3'd2;
  localparam mode_t MODE_ASCENSION   = 3'd3;
  localparam mode_t MODE_WHITSUN     = 3'd4;

  // Offsets from Easter Sunday, in days
  localparam doy_t CARNIVAL_BACK    = 9'd49;
  localparam doy_t GOOD_FRIDAY_BACK = 9'd2;
  localparam doy_t ASCENSION_FWD    = 9'd39;
  localparam doy_t WHITSUN_FWD      = 9'd49;

  // Days before the first of each month, common year
  localparam doy_t DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [7:0] q;
    logic [6:0] r;
  } divmod100_t;

  // Ordinal of the day before the first of month m (1..12)
  function automatic doy_t month_start(input month_t m, input logic leap);
    doy_t base;
    base = DAYS_BEFORE[4'(m - 4'd1)];
    return base + ((m > 4'd2) ? 9'(leap) : 9'd0);
  endfunction

  // y / 100 and y % 100: reciprocal estimate, then one correction step
  function automatic divmod100_t divmod100(input year_t y);
    logic [29:0] prod;
    logic [7:0]  q0;
    logic [13:0] r0;
    divmod100_t  res;
    prod = 30'(y) * 30'd10485;
    q0   = prod[27:20];
    r0   = y - 14'(14'(q0) * 14'd100);
    if (r0 >= 14'd100) begin
      res.q = q0 + 8'd1;
      res.r = 7'(r0 - 14'd100);
    end else begin
      res.q = q0;
      res.r = 7'(r0);
    end
    return res;
  endfunction

  // y % 19
  function automatic logic [4:0] mod19(input year_t y);
    logic [29:0] prod;
    logic [9:0]  q0;
    logic [13:0] r0;
    prod = 30'(y) * 30'd55188;
    q0   = prod[29:20];
    r0   = y - 14'(14'(q0) * 14'd19);
    return (r0 >= 14'd19) ? 5'(r0 - 14'd19) : 5'(r0);
  endfunction

  // x / 25 for x up to 171
  function automatic logic [2:0] div25(input logic [7:0] x);
    logic [13:0] prod;
    logic [3:0]  q0;
    logic [7:0]  r0;
    prod = 14'(x) * 14'd40;
    q0   = prod[13:10];
    r0   = x - 8'(8'(q0) * 8'd25);
    return (r0 >= 8'd25) ? 3'(q0 + 4'd1) : 3'(q0);
  endfunction

  // x / 3 for x up to 164
  function automatic logic [5:0] div3(input logic [7:0] x);
    logic [17:0] prod;
    logic [7:0]  q0;
    logic [7:0]  r0;
    prod = 18'(x) * 18'd341;
    q0   = prod[17:10];
    r0   = x - 8'(q0 * 8'd3);
    return (r0 >= 8'd3) ? 6'(q0 + 8'd1) : 6'(q0);
  endfunction

  // x % 30 for x below 1024
  function automatic logic [4:0] mod30(input logic [9:0] x);
    logic [17:0] prod;
    logic [5:0]  q0;
    logic [9:0]  r0;
    prod = 18'(x) * 18'd136;
    q0   = prod[17:12];
    r0   = x - 10'(10'(q0) * 10'd30);
    return (r0 >= 10'd30) ? 5'(r0 - 10'd30) : 5'(r0);
  endfunction

  // x % 7 for x below 128
  function automatic logic [2:0] mod7(input logic [6:0] x);
    logic [12:0] prod;
    logic [4:0]  q0;
    logic [6:0]  r0;
    prod = 13'(x) * 13'd36;
    q0   = prod[12:8];
    r0   = x - 7'(7'(q0) * 7'd7);
    return (r0 >= 7'd7) ? 3'(r0 - 7'd7) : 3'(r0);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ehd_if.sv =====
`default_nettype none

// Request channel: year and holiday selector
interface ehd_in_if import ehd_pkg::*; ();
  logic  valid;
  logic  ready;
  year_t year;
  mode_t mode;

  modport source (output valid, output year, output mode, input ready);
  modport sink   (input valid, input year, input mode, output ready);
endinterface

// Result channel: holiday date
interface ehd_out_if import ehd_pkg::*; ();
  logic   valid;
  logic   ready;
  month_t month;
  day_t   day;
  doy_t   day_of_year;

  modport source (output valid, output month, output day, output day_of_year, input ready);
  modport sink   (input valid, input month, input day, input day_of_year, output ready);
endinterface

`default_nettype wire

// ===== sv/easter_holiday_date.sv =====
// easter_holiday_date: date of Easter and its movable feasts.
//
// in_ch carries one word per request: year (14 bits) and mode
// (0 Easter, 1 Carnival, 2 Good Friday, 3 Ascension, 4 Whitsuntide;
// 5..7 act as Easter). out_ch returns one word per request, in order:
// month, day of month and day of year of the selected holiday.
//
// The pipeline has 8 register stages (divisions of the year, epact,
// weekday, Easter ordinal, offset, month search) and takes one word every
// cycle unless a stall on out_ch.ready has filled every stage.
//
// Reset (rst_n low at a clock edge) drops every word in flight; out_ch.valid
// is low from the next cycle on. When out_ch.ready is low the output holds
// its word, and upstream stages keep filling any empty slots, so in_ch.ready
// falls only once all 8 stages are full. Nothing is lost or repeated.
`default_nettype none

module easter_holiday_date import ehd_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  ehd_in_if.sink    in_ch,
  ehd_out_if.source out_ch
);

  // Stage valids and per-stage advance
  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] adv;

  always_comb begin
    adv[NSTAGE-1] = !v_r[NSTAGE-1] || out_ch.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = adv[0];

  // Stage 0: golden number, century, year in century
  logic [4:0] s0_golden_r, s0_golden_nxt;
  logic [7:0] s0_century_r, s0_century_nxt;
  logic [6:0] s0_yr_r, s0_yr_nxt;
  mode_t      s0_mode_r;
  divmod100_t s0_dm;

  always_comb begin
    s0_dm          = divmod100(in_ch.year);
    s0_golden_nxt  = mod19(in_ch.year);
    s0_century_nxt = s0_dm.q;
    s0_yr_nxt      = s0_dm.r;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_golden_r  <= s0_golden_nxt;
      s0_century_r <= s0_century_nxt;
      s0_yr_r      <= s0_yr_nxt;
      s0_mode_r    <= in_ch.mode;
    end
  end

  // Stage 1: f term, partial epact sum, century/year splits, leap flag
  logic [4:0] s1_golden_r;
  logic [7:0] s1_century_r;
  logic [2:0] s1_f_r, s1_f_nxt;
  logic [9:0] s1_p_r, s1_p_nxt;
  logic [1:0] s1_cmod4_r;
  logic [4:0] s1_ydiv4_r;
  logic [1:0] s1_ymod4_r;
  logic       s1_leap_r, s1_leap_nxt;
  mode_t      s1_mode_r;

  always_comb begin
    s1_f_nxt    = div25(s0_century_r + 8'd8);
    s1_p_nxt    = 10'(s0_golden_r) * 10'd19 + 10'(s0_century_r) + 10'd15
                  - 10'(s0_century_r[7:2]);
    // divisible by 4, and not a century unless divisible by 400
    s1_leap_nxt = (s0_yr_r[1:0] == 2'd0)
                  && ((s0_yr_r != 7'd0) || (s0_century_r[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_golden_r  <= s0_golden_r;
      s1_century_r <= s0_century_r;
      s1_f_r       <= s1_f_nxt;
      s1_p_r       <= s1_p_nxt;
      s1_cmod4_r   <= s0_century_r[1:0];
      s1_ydiv4_r   <= s0_yr_r[6:2];
      s1_ymod4_r   <= s0_yr_r[1:0];
      s1_leap_r    <= s1_leap_nxt;
      s1_mode_r    <= s0_mode_r;
    end
  end

  // Stage 2: g term, raw epact
  logic [4:0] s2_golden_r;
  logic [9:0] s2_eraw_r, s2_eraw_nxt;
  logic [5:0] s2_g;
  logic [1:0] s2_cmod4_r;
  logic [4:0] s2_ydiv4_r;
  logic [1:0] s2_ymod4_r;
  logic       s2_leap_r;
  mode_t      s2_mode_r;

  always_comb begin
    s2_g        = div3(s1_century_r - 8'(s1_f_r) + 8'd1);
    s2_eraw_nxt = s1_p_r - 10'(s2_g);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_golden_r <= s1_golden_r;
      s2_eraw_r   <= s2_eraw_nxt;
      s2_cmod4_r  <= s1_cmod4_r;
      s2_ydiv4_r  <= s1_ydiv4_r;
      s2_ymod4_r  <= s1_ymod4_r;
      s2_leap_r   <= s1_leap_r;
      s2_mode_r   <= s1_mode_r;
    end
  end

  // Stage 3: epact
  logic [4:0] s3_golden_r;
  logic [4:0] s3_epact_r, s3_epact_nxt;
  logic [1:0] s3_cmod4_r;
  logic [4:0] s3_ydiv4_r;
  logic [1:0] s3_ymod4_r;
  logic       s3_leap_r;
  mode_t      s3_mode_r;

  always_comb begin
    s3_epact_nxt = mod30(s2_eraw_r);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_golden_r <= s2_golden_r;
      s3_epact_r  <= s3_epact_nxt;
      s3_cmod4_r  <= s2_cmod4_r;
      s3_ydiv4_r  <= s2_ydiv4_r;
      s3_ymod4_r  <= s2_ymod4_r;
      s3_leap_r   <= s2_leap_r;
      s3_mode_r   <= s2_mode_r;
    end
  end

  // Stage 4: weekday correction; the sum never goes below zero
  logic [4:0] s4_golden_r;
  logic [4:0] s4_epact_r;
  logic [2:0] s4_wk_r, s4_wk_nxt;
  logic [7:0] s4_wsum;
  logic       s4_leap_r;
  mode_t      s4_mode_r;

  always_comb begin
    s4_wsum   = 8'd32 + {5'd0, s3_cmod4_r, 1'b0} + {2'd0, s3_ydiv4_r, 1'b0}
                - 8'(s3_epact_r) - 8'(s3_ymod4_r);
    s4_wk_nxt = mod7(s4_wsum[6:0]);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_golden_r <= s3_golden_r;
      s4_epact_r  <= s3_epact_r;
      s4_wk_r     <= s4_wk_nxt;
      s4_leap_r   <= s3_leap_r;
      s4_mode_r   <= s3_mode_r;
    end
  end

  // Stage 5: Easter as 31*month + day - 1; the /451 term is 0 or 1
  logic [7:0] s5_base_r, s5_base_nxt;
  logic [8:0] s5_csum;
  logic       s5_leap_r;
  mode_t      s5_mode_r;

  always_comb begin
    s5_csum     = 9'(s4_golden_r) + 9'(s4_epact_r) * 9'd11 + 9'(s4_wk_r) * 9'd22;
    s5_base_nxt = 8'(s4_epact_r) + 8'(s4_wk_r) + 8'd114
                  - ((s5_csum >= 9'd451) ? 8'd7 : 8'd0);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_base_r <= s5_base_nxt;
      s5_leap_r <= s4_leap_r;
      s5_mode_r <= s4_mode_r;
    end
  end

  // Stage 6: Easter ordinal, then the holiday offset
  // base stays in 114..149, so Easter is in March or April
  doy_t       s6_doy_r, s6_doy_nxt;
  doy_t       s6_easter;
  logic       s6_april;
  logic [4:0] s6_mday;
  logic       s6_leap_r;

  always_comb begin
    s6_april  = (s5_base_r >= 8'd124);
    s6_mday   = s6_april ? 5'(s5_base_r - 8'd123) : 5'(s5_base_r - 8'd92);
    s6_easter = 9'(s6_mday) + (s6_april ? DAYS_BEFORE[3] : DAYS_BEFORE[2])
                + 9'(s5_leap_r);
    case (s5_mode_r)
      MODE_CARNIVAL:    s6_doy_nxt = s6_easter - CARNIVAL_BACK;
      MODE_GOOD_FRIDAY: s6_doy_nxt = s6_easter - GOOD_FRIDAY_BACK;
      MODE_ASCENSION:   s6_doy_nxt = s6_easter + ASCENSION_FWD;
      MODE_WHITSUN:     s6_doy_nxt = s6_easter + WHITSUN_FWD;
      default:          s6_doy_nxt = s6_easter;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_doy_r  <= s6_doy_nxt;
      s6_leap_r <= s5_leap_r;
    end
  end

  // Stage 7: last month starting on or before the ordinal; output register
  month_t month_r, month_nxt;
  day_t   day_r, day_nxt;
  doy_t   doy_r;

  always_comb begin
    month_nxt = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (s6_doy_r > month_start(4'(i), s6_leap_r)) month_nxt = 4'(i);
    end
    day_nxt = 5'(s6_doy_r - month_start(month_nxt, s6_leap_r));
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      month_r <= month_nxt;
      day_r   <= day_nxt;
      doy_r   <= s6_doy_r;
    end
  end

  assign out_ch.valid       = v_r[NSTAGE-1];
  assign out_ch.month       = month_r;
  assign out_ch.day         = day_r;
  assign out_ch.day_of_year = doy_r;

endmodule

`default_nettype wire

// ===== sv/ehd_check.sv =====
`default_nettype none
`include "easter_holiday_date_assert.svh"

module ehd_check import ehd_pkg::*; (
  input wire    clk,
  input wire    rst_n,
  input wire    out_valid,
  input wire    out_ready,
  input month_t out_month,
  input day_t   out_day,
  input doy_t   out_day_of_year
);

  // stalled result word holds
  `EHD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_month) && $stable(out_day) && $stable(out_day_of_year), "result word changed while stalled")

  // reset empties the pipeline
  `EHD_ASSERT_ALWAYS(a_reset_flush, !rst_n |=> !out_valid, "result valid right after reset")

  // every feast falls between February 1 and mid June
  `EHD_ASSERT(a_doy_range, out_valid |-> out_day_of_year >= 9'd32 && out_day_of_year <= 9'd165 && out_month >= 4'd2 && out_month <= 4'd6 && out_day >= 5'd1, "holiday date out of range")

  // February dates agree across fields
  `EHD_ASSERT(a_feb_agree, out_valid && out_month == 4'd2 |-> out_day_of_year == 9'(out_day) + 9'd31, "month, day and day of year disagree")

endmodule

bind easter_holiday_date ehd_check u_ehd_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_month       (out_ch.month),
  .out_day         (out_ch.day),
  .out_day_of_year (out_ch.day_of_year)
);

`default_nettype wire
